// ----- rtl/core/ugpc_pkg.sv -----
// ugpc_pkg: constants, types and helper functions of the go-to-goal-pose controller
// angles are radians scaled by 2^16; used by unicycle_goal_pose_controller_top
`timescale 1ns / 1ps
`default_nettype none

package ugpc_pkg;

    localparam int CW = 36;

    localparam logic [2:0] REG_GOAL_X       = 3'd0;
    localparam logic [2:0] REG_GOAL_Y       = 3'd1;
    localparam logic [2:0] REG_GOAL_HEADING = 3'd2;
    localparam logic [2:0] REG_FLAGS        = 3'd3;
    localparam logic [2:0] REG_GAINS        = 3'd4;
    localparam logic [2:0] REG_LIMITS       = 3'd5;
    localparam logic [2:0] REG_TOLERANCES   = 3'd6;

    localparam logic signed [21:0] ANG_PI  = 22'sd205887;
    localparam logic signed [21:0] ANG_2PI = 22'sd411774;
    localparam logic [17:0] PI_U   = 18'd205887;
    localparam logic [17:0] PI_2_U = 18'd102944;
    localparam logic [17:0] PI_3_U = 18'd68629;
    localparam logic [33:0] DIST_2M = 34'd131072;
    localparam logic [33:0] DIST_3M = 34'd196608;
    localparam logic [15:0] INV_GAIN = 16'd39797;

    // reciprocals for the constant divisions
    localparam longint unsigned DIVPI_L = (64'd1 << 40) / 64'd205887;
    localparam logic [22:0] DIVPI_M = DIVPI_L[22:0];
    localparam longint unsigned DIV3_L = ((64'd1 << 23) + 64'd2) / 64'd3;
    localparam logic [21:0] DIV3_M = DIV3_L[21:0];

    typedef struct packed {
        logic [18:0] th;
        logic [18:0] f;
        logic [18:0] bearing;
        logic [18:0] e;
        logic [18:0] back;
        logic [33:0] d;
        logic [49:0] pv;
        logic [17:0] af;
        logic [17:0] ae;
        logic [17:0] rem;
        logic        dlt_ptol;
        logic        dlt2;
        logic        dlt3;
        logic        fwd;
        logic        slow;
        logic        blend;
        logic        bneg;
        logic        wen;
        logic        eneg;
        logic        reached;
        logic [14:0] vdes;
        logic [37:0] pe;
        logic [37:0] pf;
        logic [32:0] n;
        logic [21:0] bq;
        logic [15:0] q0;
        logic [33:0] qd;
        logic [19:0] bq3;
        logic [15:0] v;
        logic [18:0] err;
        logic [22:0] tm;
    } t_post;

    // one correction step brings anything within three pi back into range
    function automatic logic [18:0] wrap_ang(input logic signed [21:0] a);
        logic signed [21:0] r;
        r = a;
        if (a > ANG_PI) begin
            r = a - ANG_2PI;
        end else if (a < -ANG_PI) begin
            r = a + ANG_2PI;
        end
        return r[18:0];
    endfunction

    function automatic logic [17:0] abs_ang(input logic [18:0] a);
        logic [18:0] t;
        t = a[18] ? (~a + 19'd1) : a;
        return t[17:0];
    endfunction

    function automatic logic [15:0] atan_at(input int i);
        logic [15:0] r;
        case (i)
            0:       r = 16'd51472;
            1:       r = 16'd30386;
            2:       r = 16'd16055;
            3:       r = 16'd8150;
            4:       r = 16'd4091;
            5:       r = 16'd2047;
            6:       r = 16'd1024;
            7:       r = 16'd512;
            8:       r = 16'd256;
            9:       r = 16'd128;
            10:      r = 16'd64;
            11:      r = 16'd32;
            12:      r = 16'd16;
            13:      r = 16'd8;
            14:      r = 16'd4;
            15:      r = 16'd2;
            16:      r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/unicycle_goal_pose_controller_top.sv -----
// unicycle_goal_pose_controller_top: pipelined go-to-goal-pose controller
// vectoring cordic for distance and bearing, then a fixed-point control pipeline; uses ugpc_pkg
//
//   channel | signals                                          | direction
//   pose    | start, busy, i_pose_x, i_pose_y, i_pose_heading  | in
//   config  | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data| in
//   command | o_strobe, o_linear_velocity, o_angular_velocity, | out
//           | o_goal_reached                                   |
//
// one pose word is taken every cycle while busy is low; the command word for it strobes once
// it has passed the pre-rotation stage, the cordic stages, eight control stages
// (multiplies and the reciprocal divisions) and the output register
// busy is high only during reset and until the first edge after it; the pipeline never
// stalls since the command side cannot hold words off
`timescale 1ns / 1ps
`default_nettype none

module unicycle_goal_pose_controller_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire signed [31:0]  i_pose_x,
    input  wire signed [31:0]  i_pose_y,
    input  wire signed [15:0]  i_pose_heading,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [2:0]          i_cfg_index,
    input  wire [31:0]         i_cfg_data,
    output logic               o_strobe,
    output logic signed [15:0] o_linear_velocity,
    output logic signed [15:0] o_angular_velocity,
    output logic               o_goal_reached
);

    localparam int CW = ugpc_pkg::CW;
    localparam int N = CORDIC_STAGES;

    logic        r_rdy;
    logic [31:0] r_goal_x, r_goal_y, r_gains, r_limits, r_tols;
    logic [15:0] r_goal_heading;
    logic [2:0]  r_flags;

    logic        acc;
    logic [15:0] kp, kth;
    logic [14:0] vcap, wcap;
    logic [19:0] ptol;
    logic [18:0] atol;
    logic        has_t, mwr, gset;

    assign acc = start && !busy;
    assign busy = !r_rdy;
    assign o_cfg_ready = r_rdy;
    assign kp = r_gains[31:16];
    assign kth = r_gains[15:0];
    assign vcap = r_limits[31] ? 15'h7fff : r_limits[30:16];
    assign wcap = r_limits[15] ? 15'h7fff : r_limits[14:0];
    assign ptol = {r_tols[31:16], 4'b0000};
    assign atol = {r_tols[15:0], 3'b000};
    assign gset = r_flags[0];
    assign has_t = r_flags[1];
    assign mwr = r_flags[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_goal_heading <= '0;
            r_flags <= 3'd4;
            r_gains <= '0;
            r_limits <= '0;
            r_tols <= '0;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_valid && r_rdy) begin
                case (i_cfg_index)
                    ugpc_pkg::REG_GOAL_X:       r_goal_x <= i_cfg_data;
                    ugpc_pkg::REG_GOAL_Y:       r_goal_y <= i_cfg_data;
                    ugpc_pkg::REG_GOAL_HEADING: r_goal_heading <= i_cfg_data[15:0];
                    ugpc_pkg::REG_FLAGS:        r_flags <= i_cfg_data[2:0];
                    ugpc_pkg::REG_GAINS:        r_gains <= i_cfg_data;
                    ugpc_pkg::REG_LIMITS:       r_limits <= i_cfg_data;
                    ugpc_pkg::REG_TOLERANCES:   r_tols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // input stage: offsets to the goal and wrapped heading
    logic                 r_s0_vld;
    logic signed [CW-1:0] r_s0_dx, r_s0_dy;
    logic [18:0]          r_s0_th;
    logic signed [CW-1:0] n_dx, n_dy;
    logic [18:0]          n_th;

    assign n_dx = {{4{r_goal_x[31]}}, r_goal_x} - {{4{i_pose_x[31]}}, i_pose_x};
    assign n_dy = {{4{r_goal_y[31]}}, r_goal_y} - {{4{i_pose_y[31]}}, i_pose_y};
    assign n_th = ugpc_pkg::wrap_ang({{3{i_pose_heading[15]}}, i_pose_heading, 3'b000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= acc;
        end
        if (acc) begin
            r_s0_dx <= n_dx;
            r_s0_dy <= n_dy;
            r_s0_th <= n_th;
        end
    end

    // pre-rotation into the right half plane, then the cordic stages
    logic signed [CW-1:0] r_cx [0:N];
    logic signed [CW-1:0] r_cy [0:N];
    logic signed [21:0]   r_cz [0:N];
    logic [18:0]          r_cth [0:N];
    logic [18:0]          r_cf [0:N];
    logic [N:0]           r_czero;
    logic [N:0]           r_cvld;

    logic                 pre_neg;
    logic signed [CW-1:0] pre_x, pre_y;
    logic signed [21:0]   pre_z;
    logic [18:0]          pre_f;

    assign pre_neg = r_s0_dx[CW-1];
    assign pre_x = pre_neg ? -r_s0_dx : r_s0_dx;
    assign pre_y = pre_neg ? -r_s0_dy : r_s0_dy;
    assign pre_z = !pre_neg ? 22'sd0 : (r_s0_dy[CW-1] ? -ugpc_pkg::ANG_PI : ugpc_pkg::ANG_PI);
    assign pre_f = ugpc_pkg::wrap_ang({{3{r_goal_heading[15]}}, r_goal_heading, 3'b000}
                                      - {{3{r_s0_th[18]}}, r_s0_th});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
        end else begin
            r_cvld <= {r_cvld[N-1:0], r_s0_vld};
        end
        r_cx[0] <= pre_x;
        r_cy[0] <= pre_y;
        r_cz[0] <= pre_z;
        r_cth[0] <= r_s0_th;
        r_cf[0] <= pre_f;
        r_czero[0] <= (r_s0_dx == '0) && (r_s0_dy == '0);
        for (int k = 0; k < N; k++) begin
            if (r_cy[k] > 0) begin
                r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                r_cz[k+1] <= r_cz[k] + {6'b0, ugpc_pkg::atan_at(k)};
            end else begin
                r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                r_cz[k+1] <= r_cz[k] - {6'b0, ugpc_pkg::atan_at(k)};
            end
            r_cth[k+1] <= r_cth[k];
            r_cf[k+1] <= r_cf[k];
            r_czero[k+1] <= r_czero[k];
        end
    end

    // control pipeline
    ugpc_pkg::t_post n_pa, n_pb, n_pc, n_pd, n_pe, n_pf, n_pg, n_ph;
    ugpc_pkg::t_post r_pa, r_pb, r_pc, r_pd, r_pe, r_pf, r_pg, r_ph;
    logic [7:0] r_pvld;

    logic [CW-2:0]      xc;
    logic [50:0]        dprod;
    logic signed [21:0] bdiff;
    logic [33:0]        vraw;
    logic [17:0]        aback, d18;
    logic signed [37:0] me_d, me_e, mf_d, mf_f, bsum, babs;
    logic [55:0]        qp;
    logic [43:0]        bp;
    logic [33:0]        rr;
    logic [15:0]        vs;
    logic [14:0]        vsl;
    logic [18:0]        eb, em;
    logic [17:0]        aerr;
    logic [33:0]        tp;

    always_comb begin
        n_pa = '0;
        xc = r_cx[N][CW-1] ? '0 : r_cx[N][CW-2:0];
        dprod = 51'(xc) * 51'(ugpc_pkg::INV_GAIN) + 51'd32768;
        n_pa.d = dprod[49:16];
        n_pa.bearing = r_czero[N] ? '0 : ugpc_pkg::wrap_ang(r_cz[N]);
        n_pa.th = r_cth[N];
        n_pa.f = r_cf[N];
    end

    always_comb begin
        n_pb = r_pa;
        bdiff = {{3{r_pa.bearing[18]}}, r_pa.bearing} - {{3{r_pa.th[18]}}, r_pa.th};
        n_pb.e = ugpc_pkg::wrap_ang(bdiff);
        n_pb.back = ugpc_pkg::wrap_ang(bdiff - ugpc_pkg::ANG_PI);
        n_pb.pv = 50'(kp) * 50'(r_pa.d);
        n_pb.dlt_ptol = r_pa.d < 34'(ptol);
        n_pb.dlt2 = r_pa.d < ugpc_pkg::DIST_2M;
        n_pb.dlt3 = r_pa.d < ugpc_pkg::DIST_3M;
        n_pb.af = ugpc_pkg::abs_ang(r_pa.f);
    end

    always_comb begin
        n_pc = r_pb;
        vraw = r_pb.pv[49:16];
        n_pc.vdes = (vraw > 34'(vcap)) ? vcap : vraw[14:0];
        n_pc.ae = ugpc_pkg::abs_ang(r_pb.e);
        aback = ugpc_pkg::abs_ang(r_pb.back);
        n_pc.fwd = !((n_pc.ae >= ugpc_pkg::PI_2_U) && has_t && (aback < n_pc.ae));
        n_pc.slow = n_pc.ae > ugpc_pkg::PI_3_U;
        n_pc.rem = ugpc_pkg::PI_U - n_pc.ae;
        n_pc.blend = has_t && r_pb.dlt3;
        // blend weights are only used below three metres, so 18 bits of distance do
        d18 = r_pb.d[17:0];
        me_d = $signed({20'b0, d18});
        me_e = $signed({{19{r_pb.e[18]}}, r_pb.e});
        mf_d = $signed({20'b0, ugpc_pkg::DIST_3M[17:0] - d18});
        mf_f = $signed({{19{r_pb.f[18]}}, r_pb.f});
        n_pc.pe = me_d * me_e;
        n_pc.pf = mf_d * mf_f;
    end

    always_comb begin
        n_pd = r_pc;
        n_pd.n = 33'(r_pc.vdes) * 33'(r_pc.rem);
        bsum = $signed(r_pc.pe) + $signed(r_pc.pf);
        n_pd.bneg = bsum[37];
        babs = bsum[37] ? -bsum : bsum;
        n_pd.bq = babs[37:16];
    end

    // quotient estimates, low by at most one for the pi division
    always_comb begin
        n_pe = r_pd;
        qp = 56'(r_pd.n) * 56'(ugpc_pkg::DIVPI_M);
        n_pe.q0 = qp[55:40];
        bp = 44'(r_pd.bq) * 44'(ugpc_pkg::DIV3_M);
        n_pe.bq3 = bp[42:23];
    end

    always_comb begin
        n_pf = r_pe;
        n_pf.qd = 34'(r_pe.q0) * 34'(ugpc_pkg::PI_U);
    end

    always_comb begin
        n_pg = r_pf;
        rr = 34'(r_pf.n) - r_pf.qd;
        vs = (rr >= 34'(ugpc_pkg::PI_U)) ? r_pf.q0 + 16'd1 : r_pf.q0;
        vsl = r_pf.slow ? vs[14:0] : r_pf.vdes;
        eb = r_pf.bneg ? -{1'b0, r_pf.bq3[17:0]} : {1'b0, r_pf.bq3[17:0]};
        em = r_pf.blend ? eb : r_pf.e;
        n_pg.reached = r_pf.dlt_ptol && (!has_t || (r_pf.af < atol[17:0] || atol[18]));
        n_pg.v = '0;
        n_pg.err = r_pf.e;
        n_pg.wen = 1'b1;
        if (!gset) begin
            n_pg.wen = 1'b0;
            n_pg.reached = 1'b0;
        end else if (r_pf.dlt_ptol) begin
            n_pg.err = r_pf.f;
            n_pg.wen = has_t && (19'(r_pf.af) > atol);
        end else if (!mwr) begin
            if (has_t && r_pf.dlt2 && (20'(r_pf.af) > {atol, 1'b0})) begin
                n_pg.err = r_pf.f;
            end else if (19'(r_pf.ae) > atol) begin
                n_pg.err = r_pf.e;
            end else begin
                n_pg.v = {1'b0, r_pf.vdes};
            end
        end else begin
            n_pg.err = em;
            n_pg.v = r_pf.fwd ? {1'b0, vsl} : -{1'b0, vsl};
        end
    end

    always_comb begin
        n_ph = r_pg;
        aerr = ugpc_pkg::abs_ang(r_pg.err);
        tp = 34'(aerr) * 34'(kth);
        n_ph.tm = tp[33:11];
        n_ph.eneg = r_pg.err[18];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= '0;
        end else begin
            r_pvld <= {r_pvld[6:0], r_cvld[N]};
        end
        r_pa <= n_pa;
        r_pb <= n_pb;
        r_pc <= n_pc;
        r_pd <= n_pd;
        r_pe <= n_pe;
        r_pf <= n_pf;
        r_pg <= n_pg;
        r_ph <= n_ph;
    end

    // output word
    logic        r_out_vld;
    logic [15:0] r_out_v, r_out_w;
    logic        r_out_reached;
    logic [14:0] wm;
    logic [15:0] n_w;

    assign wm = (r_ph.tm > 23'(wcap)) ? wcap : r_ph.tm[14:0];
    assign n_w = !r_ph.wen ? 16'd0 : (r_ph.eneg ? -{1'b0, wm} : {1'b0, wm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_pvld[7];
        end
        r_out_v <= r_ph.v;
        r_out_w <= n_w;
        r_out_reached <= r_ph.reached;
    end

    assign o_strobe = r_out_vld;
    assign o_linear_velocity = r_out_v;
    assign o_angular_velocity = r_out_w;
    assign o_goal_reached = r_out_reached;

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_s0_vld)
        else $error("accepted pose word did not enter the pipeline");

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("command strobe right after reset");

    a_reached_stops : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_goal_reached) |-> (o_linear_velocity == 16'sd0))
        else $error("goal reached but linear velocity nonzero");

endmodule

`default_nettype wire
